@@ rtl/kas_pkg.sv @@
// ----------------------------------------------------------------------------
// kas_pkg
// Shared types and constants of the knob automation sequencer: beat layouts,
// step table geometry and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package kas_pkg;

    // step table geometry
    localparam int TABLE_ENTRIES = 512;
    localparam int KNOB_COUNT    = 2;
    localparam int ENTRY_W       = 8;
    localparam int ROWS          = TABLE_ENTRIES / KNOB_COUNT;
    localparam int POS_W         = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_W         = KNOB_COUNT * ENTRY_W;

    // knob value and counter widths
    localparam int KNOB_W  = 7;
    localparam int COUNT_W = 8;

    // value shown on both outputs by an erase
    localparam logic [KNOB_W-1:0] ERASE_VALUE = 7'd127;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_BEAT = 2'd1;
    localparam logic [COUNT_W-1:0] HOLD_TICKS_RST     = 8'd16;
    localparam logic [COUNT_W-1:0] TICKS_PER_BEAT_RST = 8'd24;

    // one input beat: knob readings and button requests
    typedef struct packed {
        logic [KNOB_W-1:0] knob_a;
        logic [KNOB_W-1:0] knob_b;
        logic              erase_req;
        logic              record_toggle;
        logic              play_toggle;
        logic              start_req;
        logic              stop_req;
    } t_in_beat;

    // one output beat: parameter updates and status
    typedef struct packed {
        logic              set_a;
        logic [KNOB_W-1:0] value_a;
        logic              set_b;
        logic [KNOB_W-1:0] value_b;
        logic              beat_pulse;
        logic              running;
        logic              recording;
    } t_out_beat;

    // resolved play/record requests of one tick
    typedef struct packed {
        logic       run_next;
        logic       rec_next;
        logic [1:0] pend_next;
        logic       pos_clear;
        logic       beat_clear;
    } t_req_res;

endpackage

`default_nettype wire

@@ rtl/kas_step_ram.sv @@
// ----------------------------------------------------------------------------
// kas_step_ram
// Simple dual-port step table memory: one write port, one read port with
// registered read data. No reset on contents.
// ----------------------------------------------------------------------------
`default_nettype none

module kas_step_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output      logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/kas_req_decode.sv @@
// ----------------------------------------------------------------------------
// kas_req_decode
// Resolves the button requests of one tick against the run and record flags
// and the pending starts: stop beats start, a losing start stays pending.
// ----------------------------------------------------------------------------
`default_nettype none

module kas_req_decode (
    input  wire kas_pkg::t_in_beat i_req,
    input  wire logic              i_run,
    input  wire logic              i_rec,
    input  wire logic [1:0]        i_pend,
    output      kas_pkg::t_req_res o_res
);

    logic start_play;
    logic stop_play;
    logic start_rec;
    logic stop_rec;

    always_comb begin
        start_play = i_pend[0];
        start_rec  = i_pend[1];
        stop_play  = 1'b0;
        stop_rec   = 1'b0;

        // toggles and explicit requests
        if (i_req.record_toggle) begin
            if (i_rec) stop_rec = 1'b1;
            else       start_rec = 1'b1;
        end
        if (i_req.play_toggle) begin
            if (i_run) stop_play = 1'b1;
            else       start_play = 1'b1;
        end
        if (i_req.start_req) start_play = 1'b1;
        if (i_req.stop_req)  stop_play = 1'b1;

        // playing: stop wins and also stops recording
        o_res.run_next   = i_run;
        o_res.pos_clear  = 1'b0;
        o_res.beat_clear = 1'b0;
        if (stop_play) begin
            o_res.run_next   = 1'b0;
            o_res.pos_clear  = 1'b1;
            o_res.beat_clear = 1'b1;
            stop_rec         = 1'b1;
        end else if (start_play) begin
            start_play      = 1'b0;
            o_res.pos_clear = 1'b1;
            o_res.run_next  = 1'b1;
        end

        // recording
        o_res.rec_next = i_rec;
        if (stop_rec) begin
            o_res.rec_next = 1'b0;
        end else if (start_rec) begin
            start_rec      = 1'b0;
            o_res.rec_next = 1'b1;
        end

        o_res.pend_next = {start_rec, start_play};
    end

endmodule

`default_nettype wire

@@ rtl/knob_automation_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// knob_automation_sequencer_unit
// Records two knobs into a looping step table and replays them, with a
// hold-off after a manual knob move and a beat pulse while running.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake       | payload
//  ---------+-----------+-----------------+------------------------------
//  in       | sink      | valid / stall   | i_in_data  (t_in_beat)
//  out      | source    | valid / stall   | o_out_data (t_out_beat)
//  cfg      | sink      | valid / ready   | i_cfg_idx, i_cfg_data
//
//  A tick passes through accept, request resolve, record read-modify-write
//  of the step RAM and replay read result, in that order.
//  Reset and erase clear the table at once through per-row valid flags, so
//  there is no clearing sweep and no dead time after reset.
//  A finished result waits in the output register; the next tick is taken
//  meanwhile and holds in its replay cycle until that register is free.
//  Configuration writes are always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module knob_automation_sequencer_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input beats
    input  wire logic                                i_in_valid,
    output      logic                                o_in_stall,
    input  wire kas_pkg::t_in_beat                   i_in_data,
    // output beats
    output      logic                                o_out_valid,
    input  wire logic                                i_out_stall,
    output      kas_pkg::t_out_beat                  o_out_data,
    // configuration writes
    input  wire logic                                i_cfg_valid,
    output      logic                                o_cfg_ready,
    input  wire logic [kas_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [kas_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CTRL = 2'd1;
    localparam logic [1:0] ST_REC  = 2'd2;
    localparam logic [1:0] ST_PLAY = 2'd3;

    localparam int KC  = kas_pkg::KNOB_COUNT;
    localparam int EW  = kas_pkg::ENTRY_W;
    localparam int KW  = kas_pkg::KNOB_W;
    localparam int CW  = kas_pkg::COUNT_W;
    localparam int PW  = kas_pkg::POS_W;

    logic [1:0]                  r_state, n_state;
    kas_pkg::t_in_beat           r_in;
    logic                        r_run, r_rec;
    logic [1:0]                  r_pend;
    logic [PW-1:0]               r_pos, n_pos;
    logic [CW-1:0]               r_beat, n_beat;
    logic [CW-1:0]               r_hold [KC];
    logic [KW-1:0]               r_prev [KC];
    logic [kas_pkg::ROWS-1:0]    r_row_vld;
    logic [CW-1:0]               r_hold_ticks, r_tpb;
    logic                        r_pulse;
    logic                        r_out_valid;
    kas_pkg::t_out_beat          r_out, n_out;

    kas_pkg::t_req_res           w_req;
    logic [KW-1:0]               w_knob [KC];
    logic [KC-1:0]               w_chg;
    logic                        w_we, w_re;
    logic [PW-1:0]               w_raddr;
    logic [kas_pkg::ROW_W-1:0]   w_wdata, w_rdata;
    logic [PW-1:0]               w_pos_adv;
    logic [CW-1:0]               w_beat_inc;
    logic                        w_out_free;
    logic [KC-1:0]               w_set;
    logic [KW-1:0]               w_val [KC];

    // knob view of the held input beat
    assign w_knob[0] = r_in.knob_a;
    assign w_knob[1] = r_in.knob_b;

    always_comb begin
        for (int k = 0; k < KC; k++) begin
            w_chg[k] = (w_knob[k] != r_prev[k]);
        end
    end

    // request resolution
    kas_req_decode u_req (
        .i_req  (r_in),
        .i_run  (r_run),
        .i_rec  (r_rec),
        .i_pend (r_pend),
        .o_res  (w_req)
    );

    // position advance with wrap and beat counter step
    assign w_pos_adv  = (r_pos == PW'(kas_pkg::ROWS - 1)) ? '0 : r_pos + PW'(1);
    assign w_beat_inc = r_beat + CW'(1);

    // step RAM access control and record merge
    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_raddr = r_pos;
        for (int k = 0; k < KC; k++) begin
            if (w_chg[k]) begin
                w_wdata[k*EW +: EW] = {1'b1, w_knob[k]};
            end else if (r_row_vld[r_pos]) begin
                w_wdata[k*EW +: EW] = w_rdata[k*EW +: EW];
            end else begin
                w_wdata[k*EW +: EW] = '0;
            end
        end
        unique case (r_state)
            ST_CTRL: begin
                w_re    = 1'b1;
                w_raddr = w_req.pos_clear ? '0 : r_pos;
            end
            ST_REC: begin
                w_we    = r_rec && (|w_chg);
                w_re    = r_run;
                w_raddr = w_pos_adv;
            end
            default: begin
            end
        endcase
    end

    kas_step_ram #(
        .DEPTH (kas_pkg::ROWS),
        .WIDTH (kas_pkg::ROW_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_pos),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // replay selection and result beat
    assign w_out_free = !(r_out_valid && i_out_stall);

    always_comb begin
        for (int k = 0; k < KC; k++) begin
            w_set[k] = r_in.erase_req;
            w_val[k] = r_in.erase_req ? kas_pkg::ERASE_VALUE : '0;
            if (r_run) begin
                if (w_chg[k]) begin
                    w_set[k] = 1'b1;
                    w_val[k] = w_knob[k];
                end else if (r_row_vld[r_pos] && w_rdata[k*EW + EW - 1]) begin
                    w_set[k] = 1'b1;
                    w_val[k] = (r_hold[k] != '0) ? w_knob[k] : w_rdata[k*EW +: KW];
                end
            end
        end
        n_out.set_a      = w_set[0];
        n_out.value_a    = w_set[0] ? w_val[0] : '0;
        n_out.set_b      = w_set[1];
        n_out.value_b    = w_set[1] ? w_val[1] : '0;
        n_out.beat_pulse = r_pulse;
        n_out.running    = r_run;
        n_out.recording  = r_rec;
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_CTRL;
            ST_CTRL: n_state = ST_REC;
            ST_REC:  n_state = ST_PLAY;
            ST_PLAY: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // position and beat counter next values
    always_comb begin
        n_pos  = r_pos;
        n_beat = r_beat;
        unique case (r_state)
            ST_CTRL: begin
                if (w_req.pos_clear)  n_pos  = '0;
                if (w_req.beat_clear) n_beat = '0;
            end
            ST_REC: begin
                if (r_run) begin
                    n_pos  = w_pos_adv;
                    n_beat = (w_beat_inc >= r_tpb) ? '0 : w_beat_inc;
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_run     <= 1'b0;
            r_rec     <= 1'b0;
            r_pend    <= 2'b00;
            r_pos     <= '0;
            r_beat    <= '0;
            r_row_vld <= '0;
            r_pulse   <= 1'b0;
            for (int k = 0; k < KC; k++) begin
                r_hold[k] <= '0;
                r_prev[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_beat  <= n_beat;
            unique case (r_state)
                ST_CTRL: begin
                    r_run  <= w_req.run_next;
                    r_rec  <= w_req.rec_next;
                    r_pend <= w_req.pend_next;
                    if (r_in.erase_req) r_row_vld <= '0;
                    for (int k = 0; k < KC; k++) begin
                        if (r_hold[k] != '0) r_hold[k] <= r_hold[k] - CW'(1);
                    end
                end
                ST_REC: begin
                    if (w_we) r_row_vld[r_pos] <= 1'b1;
                    r_pulse <= r_run && (r_beat == '0);
                end
                ST_PLAY: begin
                    if (w_out_free) begin
                        for (int k = 0; k < KC; k++) begin
                            if (r_run && w_chg[k]) r_hold[k] <= r_hold_ticks;
                            r_prev[k] <= w_knob[k];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_PLAY && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PLAY && w_out_free) begin
            r_out <= n_out;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks <= kas_pkg::HOLD_TICKS_RST;
            r_tpb        <= kas_pkg::TICKS_PER_BEAT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_idx)
                kas_pkg::CFG_HOLD_TICKS:     r_hold_ticks <= i_cfg_data;
                kas_pkg::CFG_TICKS_PER_BEAT: r_tpb        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

@@ rtl/kas_checker.sv @@
// ----------------------------------------------------------------------------
// kas_checker
// Port-level checks of the knob automation sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kas_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire kas_pkg::t_out_beat o_out_data
);

    // one tick at a time: an accepted beat blocks the next cycle
    a_one_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted in back-to-back cycles");

    // a value without its set flag reads as zero
    a_value_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.set_a || o_out_data.value_a == '0) &&
                         (o_out_data.set_b || o_out_data.value_b == '0)))
        else $error("value shown without set flag");

    // beat pulse only while running
    a_pulse_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.beat_pulse) |-> o_out_data.running)
        else $error("beat pulse while stopped");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output beat changed");

endmodule

bind knob_automation_sequencer_unit kas_checker u_kas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

@@ dv/knob_automation_sequencer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// knob_automation_sequencer_unit_tb
// Self-checking bench for the knob automation sequencer. A scoreboard object
// keeps its own copy of the step table, play/record state and registers. It
// works out the output beat of every accepted tick and checks the output
// stream field by field. The stimulus starts with a directed sequence and
// then runs random phases under several register settings. Both sides idle
// at random, and once the output side holds off long enough to back up the
// input channel.
// ----------------------------------------------------------------------------
`default_nettype none

module knob_automation_sequencer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kas_pkg::*;

    // tracks sequencer state and the output beats still owed by the block
    class knob_replay_scoreboard;
        logic [ENTRY_W-1:0] steps [TABLE_ENTRIES];
        int                 pos;
        logic [COUNT_W-1:0] beat_cnt;
        logic [COUNT_W-1:0] hold_left [KNOB_COUNT];
        logic [KNOB_W-1:0]  last_knob [KNOB_COUNT];
        logic               run_on;
        logic               rec_on;
        logic [1:0]         pend;
        logic [COUNT_W-1:0] hold_ticks;
        logic [COUNT_W-1:0] ticks_per_beat;
        t_out_beat          expected_outs [$];
        int                 mismatches;
        int                 beats_checked;

        function new();
            foreach (steps[i]) steps[i] = '0;
            foreach (hold_left[k]) begin
                hold_left[k] = '0;
                last_knob[k] = '0;
            end
            pos            = 0;
            beat_cnt       = '0;
            run_on         = 1'b0;
            rec_on         = 1'b0;
            pend           = 2'b00;
            hold_ticks     = HOLD_TICKS_RST;
            ticks_per_beat = TICKS_PER_BEAT_RST;
            mismatches     = 0;
            beats_checked  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_HOLD_TICKS) hold_ticks = data;
            else if (idx == CFG_TICKS_PER_BEAT) ticks_per_beat = data;
        endfunction

        // advance the state by one accepted tick and queue its output beat
        function void note_tick(t_in_beat b);
            logic [KNOB_W-1:0]  knob [KNOB_COUNT];
            logic               upd [KNOB_COUNT];
            logic [KNOB_W-1:0]  val [KNOB_COUNT];
            logic               go_play, go_rec, halt_play, halt_rec, pulse;
            logic [ENTRY_W-1:0] entry;
            t_out_beat          want;
            knob[0] = b.knob_a;
            knob[1] = b.knob_b;
            pulse   = 1'b0;
            for (int k = 0; k < KNOB_COUNT; k++) begin
                upd[k] = 1'b0;
                val[k] = '0;
            end

            // erase clears the table and shows the erase value
            if (b.erase_req) begin
                foreach (steps[i]) steps[i] = '0;
                for (int k = 0; k < KNOB_COUNT; k++) begin
                    upd[k] = 1'b1;
                    val[k] = ERASE_VALUE;
                end
            end

            // resolve requests: stop wins, a losing start stays pending
            go_play   = pend[0];
            go_rec    = pend[1];
            halt_play = 1'b0;
            halt_rec  = 1'b0;
            if (b.record_toggle) begin
                if (rec_on) halt_rec = 1'b1;
                else go_rec = 1'b1;
            end
            if (b.play_toggle) begin
                if (run_on) halt_play = 1'b1;
                else go_play = 1'b1;
            end
            if (b.start_req) go_play = 1'b1;
            if (b.stop_req) halt_play = 1'b1;
            if (halt_play) begin
                run_on   = 1'b0;
                halt_rec = 1'b1;
                pos      = 0;
                beat_cnt = '0;
            end else if (go_play) begin
                go_play = 1'b0;
                pos     = 0;
                run_on  = 1'b1;
            end
            if (halt_rec) begin
                rec_on = 1'b0;
            end else if (go_rec) begin
                go_rec = 1'b0;
                rec_on = 1'b1;
            end
            pend = {go_rec, go_play};

            for (int k = 0; k < KNOB_COUNT; k++)
                if (hold_left[k] != '0) hold_left[k] = hold_left[k] - COUNT_W'(1);

            // record moved knobs at the current step
            if (rec_on) begin
                for (int k = 0; k < KNOB_COUNT; k++)
                    if (knob[k] != last_knob[k])
                        steps[pos * KNOB_COUNT + k] = {1'b1, knob[k]};
            end

            // advance, wrap, then replay from the new step
            if (run_on) begin
                if (beat_cnt == '0) pulse = 1'b1;
                pos++;
                beat_cnt = beat_cnt + COUNT_W'(1);
                if (beat_cnt >= ticks_per_beat) beat_cnt = '0;
                if (pos * KNOB_COUNT + KNOB_COUNT > TABLE_ENTRIES) pos = 0;
                for (int k = 0; k < KNOB_COUNT; k++) begin
                    entry = steps[pos * KNOB_COUNT + k];
                    if (knob[k] != last_knob[k]) begin
                        hold_left[k] = hold_ticks;
                        upd[k]       = 1'b1;
                        val[k]       = knob[k];
                    end else if (entry[ENTRY_W-1]) begin
                        upd[k] = 1'b1;
                        val[k] = (hold_left[k] != '0) ? knob[k] : entry[KNOB_W-1:0];
                    end
                end
            end

            for (int k = 0; k < KNOB_COUNT; k++) last_knob[k] = knob[k];

            want.set_a      = upd[0];
            want.value_a    = upd[0] ? val[0] : '0;
            want.set_b      = upd[1];
            want.value_b    = upd[1] ? val[1] : '0;
            want.beat_pulse = pulse;
            want.running    = run_on;
            want.recording  = rec_on;
            expected_outs.push_back(want);
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_out(t_out_beat got);
            t_out_beat want;
            if (expected_outs.size() == 0) begin
                $display("%0t: unexpected output beat, expected none, actual %p",
                         $time, got);
                mismatches++;
                return;
            end
            want = expected_outs.pop_front();
            beats_checked++;
            compare("set_a", 8'(want.set_a), 8'(got.set_a));
            compare("value_a", 8'(want.value_a), 8'(got.value_a));
            compare("set_b", 8'(want.set_b), 8'(got.set_b));
            compare("value_b", 8'(want.value_b), 8'(got.value_b));
            compare("beat_pulse", 8'(want.beat_pulse), 8'(got.beat_pulse));
            compare("running", 8'(want.running), 8'(got.running));
            compare("recording", 8'(want.recording), 8'(got.recording));
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_beat              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_beat             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = CFG_HOLD_TICKS;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    knob_replay_scoreboard sb = new();
    logic [KNOB_W-1:0]     knob_now [KNOB_COUNT];

    knob_automation_sequencer_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_beat mk_tick(int a, int b, bit erase, bit rtog, bit ptog,
                                         bit start, bit stop);
        t_in_beat t;
        t.knob_a        = a[KNOB_W-1:0];
        t.knob_b        = b[KNOB_W-1:0];
        t.erase_req     = erase;
        t.record_toggle = rtog;
        t.play_toggle   = ptog;
        t.start_req     = start;
        t.stop_req      = stop;
        return t;
    endfunction

    // random tick: knobs mostly steady so replay shows, requests at given odds
    function automatic t_in_beat rand_tick(int req_odds, int move_odds);
        int r;
        for (int k = 0; k < KNOB_COUNT; k++) begin
            if ($urandom_range(1, move_odds) == 1) begin
                r = $urandom_range(0, 7);
                if (r == 0) knob_now[k] = '0;
                else if (r == 1) knob_now[k] = '1;
                else knob_now[k] = KNOB_W'($urandom_range(0, 127));
            end
        end
        return mk_tick(int'(knob_now[0]), int'(knob_now[1]),
                       $urandom_range(1, req_odds * 4) == 1,
                       $urandom_range(1, req_odds) == 1,
                       $urandom_range(1, req_odds) == 1,
                       $urandom_range(1, req_odds) == 1,
                       $urandom_range(1, req_odds) == 1);
    endfunction

    // offer each tick in turn; valid drops after the last one
    task automatic play_plan(ref t_in_beat plan [$]);
        int gap;
        int calm;
        calm = 0;
        for (int i = 0; i < plan.size(); i++) begin
            i_in_valid <= 1'b1;
            i_in_data  <= plan[i];
            do @(posedge i_clk); while (o_in_stall);
            sb.note_tick(plan[i]);
            if (calm > 0) begin
                calm--;
                gap = 0;
            end else begin
                gap = pick_gap();
                if ($urandom_range(0, 49) == 0) calm = $urandom_range(20, 120);
            end
            if (i == plan.size() - 1 && gap == 0) gap = 1;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // both registers back to back, valid held across the pair
    task automatic write_regs(logic [CFG_DATA_W-1:0] hold, logic [CFG_DATA_W-1:0] tpb);
        i_cfg_valid <= 1'b1;
        i_cfg_idx   <= CFG_HOLD_TICKS;
        i_cfg_data  <= hold;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(CFG_HOLD_TICKS, hold);
        i_cfg_idx  <= CFG_TICKS_PER_BEAT;
        i_cfg_data <= tpb;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(CFG_TICKS_PER_BEAT, tpb);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.expected_outs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // output side: check accepted beats, drive random stall
    initial begin : out_side
        int  stall_left;
        int  calm_left;
        int  gap;
        bit  pressure_done;
        stall_left    = 0;
        calm_left     = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_out(o_out_data);
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!pressure_done && sb.beats_checked >= 300) begin
                // long hold-off so the block backs up into the input channel
                pressure_done = 1'b1;
                stall_left    = 400;
                i_out_stall  <= 1'b1;
            end else if (calm_left > 0) begin
                calm_left--;
                i_out_stall <= 1'b0;
            end else begin
                gap = pick_gap();
                if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 300);
                if (gap > 0) begin
                    stall_left   = gap - 1;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // main stimulus
    initial begin : stim
        t_in_beat plan [$];
        int       hold_set [6];
        int       tpb_set [6];
        int       req_odds [6];
        int       move_odds [6];
        hold_set  = '{0, 3, 255, 0, 1, 0};
        tpb_set   = '{1, 0, 255, 0, 2, 0};
        req_odds  = '{12, 40, 2000, 25, 2000, 60};
        move_odds = '{4, 3, 300, 6, 40, 5};
        hold_set[3] = $urandom_range(0, 255);
        tpb_set[3]  = $urandom_range(1, 255);
        hold_set[5] = $urandom_range(0, 255);
        tpb_set[5]  = $urandom_range(1, 255);
        for (int k = 0; k < KNOB_COUNT; k++) knob_now[k] = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every request, stop over start, erase with replay
        plan.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
        plan.push_back(mk_tick(127, 127, 1, 0, 0, 0, 0));
        plan.push_back(mk_tick(127, 127, 0, 1, 0, 1, 0));
        plan.push_back(mk_tick(0, 127, 0, 0, 0, 0, 0));
        plan.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
        plan.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
        plan.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
        plan.push_back(mk_tick(0, 0, 0, 0, 0, 1, 1));
        plan.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
        plan.push_back(mk_tick(0, 0, 0, 1, 0, 0, 1));
        plan.push_back(mk_tick(0, 0, 0, 0, 1, 0, 0));
        plan.push_back(mk_tick(64, 33, 0, 0, 0, 0, 0));
        plan.push_back(mk_tick(64, 33, 0, 0, 0, 0, 0));
        plan.push_back(mk_tick(5, 6, 1, 0, 0, 0, 0));
        plan.push_back(mk_tick(5, 6, 1, 0, 0, 0, 0));
        plan.push_back(mk_tick(127, 0, 0, 1, 1, 1, 1));
        plan.push_back(mk_tick(127, 0, 0, 1, 0, 0, 0));
        plan.push_back(mk_tick(0, 127, 0, 0, 0, 1, 0));
        plan.push_back(mk_tick(0, 127, 0, 1, 0, 0, 0));
        plan.push_back(mk_tick(42, 85, 0, 0, 1, 0, 0));
        plan.push_back(mk_tick(42, 85, 0, 0, 1, 0, 0));
        play_plan(plan);

        // random phases, each under its own register setting
        for (int p = 0; p < 6; p++) begin
            wait_drained();
            write_regs(CFG_DATA_W'(hold_set[p]), CFG_DATA_W'(tpb_set[p]));
            plan.delete();
            for (int i = 0; i < 275; i++) begin
                plan.push_back(rand_tick(req_odds[p], move_odds[p]));
                // kick off a session at the start of each phase
                if (i == 0) plan[0].start_req = 1'b1;
                if (i == 1) plan[1].record_toggle = !sb.rec_on;
            end
            play_plan(plan);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_outs.size() == 0) begin
            $display("knob_automation_sequencer_unit_tb: clean");
        end else begin
            $display("knob_automation_sequencer_unit_tb: errors");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #10_000_000;
        $display("knob_automation_sequencer_unit_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

@@ knob_automation_sequencer_unit.f @@
rtl/kas_pkg.sv
rtl/kas_step_ram.sv
rtl/kas_req_decode.sv
rtl/knob_automation_sequencer_unit.sv
rtl/kas_checker.sv
dv/knob_automation_sequencer_unit_tb.sv
